FILE: rtl/core/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types, codes and constant tables for the grid A* path search core.
// ----------------------------------------------------------------------------
package gaps_pkg;

  // grid cell addressing: {row[2:0], col[2:0]}
  localparam int CELLS  = 64;
  localparam int CELL_W = 6;

  // Q12.8 costs
  localparam int COST_W = 20;
  localparam int KEY_W  = COST_W + CELL_W;
  localparam int HTAB_W = 12;
  localparam int HSUM_W = 13;
  localparam int HTAB_BITS = CELLS * HTAB_W;

  localparam logic [COST_W-1:0] QMAX          = 20'hFFFFF;
  localparam logic [COST_W-1:0] STEP_STRAIGHT = 20'd256;
  localparam logic [COST_W-1:0] STEP_DIAG     = 20'd362;
  localparam logic [HSUM_W-1:0] PENALTY       = 13'd2560;

  // opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // result status codes
  localparam logic [2:0] ST_PATH     = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_DST_BLK  = 3'd2;
  localparam logic [2:0] ST_SAME     = 3'd3;
  localparam logic [2:0] ST_NO_PATH  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       load_wr;
    logic       chk_rd_src;
    logic       chk_rd_dst;
    logic       set_single;
    logic [2:0] single_code;
    logic       init;
    logic       scan_start;
    logic       scan_rd;
    logic       scan_cmp;
    logic       pop_rd;
    logic       pop_wr;
    logic       nb_rd;
    logic       nb_eval;
    logic       nb_sum;
    logic       nb_ins;
    logic       k_inc;
    logic       nb_dst;
    logic       walk_rd;
    logic       walk_step;
    logic       emit_start;
    logic       emit_rd;
    logic       emit_ld;
    logic       emit_dec;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] chk_code;
    logic       open_empty;
    logic       scan_last;
    logic       nb_skip;
    logic       nb_dest;
    logic       nb_pass;
    logic       nb_better;
    logic       open_full;
    logic       k_last;
    logic       walk_stop;
    logic       emit_last;
  } sts_t;

  // round(256 * sqrt(n)), evaluated at elaboration only
  function automatic logic [HTAB_W-1:0] h_entry(input int unsigned n);
    logic [31:0] x;
    logic [31:0] res;
    logic [31:0] t;
    x   = n << 16;
    res = '0;
    for (int b = 11; b >= 0; b--) begin
      t = res | (32'd1 << b);
      if (t * t <= x) res = t;
    end
    if (x - res * res > res) res = res + 32'd1;
    return res[HTAB_W-1:0];
  endfunction

  // heuristic table indexed by {|drow|, |dcol|}
  function automatic logic [HTAB_BITS-1:0] h_table();
    logic [HTAB_BITS-1:0] tab;
    tab = '0;
    for (int a = 0; a < 8; a++) begin
      for (int b = 0; b < 8; b++) begin
        tab[(a * 8 + b) * HTAB_W +: HTAB_W] = h_entry(a * a + b * b);
      end
    end
    return tab;
  endfunction

  // neighbor row offset: N, S, E, W, NE, NW, SE, SW
  function automatic logic signed [4:0] nb_drow(input logic [2:0] k);
    case (k)
      3'd0, 3'd4, 3'd5: nb_drow = -5'sd1;
      3'd1, 3'd6, 3'd7: nb_drow = 5'sd1;
      default:          nb_drow = 5'sd0;
    endcase
  endfunction

  // neighbor column offset
  function automatic logic signed [4:0] nb_dcol(input logic [2:0] k);
    case (k)
      3'd2, 3'd4, 3'd6: nb_dcol = 5'sd1;
      3'd3, 3'd5, 3'd7: nb_dcol = -5'sd1;
      default:          nb_dcol = 5'sd0;
    endcase
  endfunction

endpackage

FILE: rtl/core/gaps_dpath.sv
// ----------------------------------------------------------------------------
// gaps_dpath
// Datapath: grid, cost and open list memories, neighbor evaluation, path walk.
// ----------------------------------------------------------------------------
module gaps_dpath #(
  parameter int GRID_ROWS  = 8,
  parameter int GRID_COLS  = 8,
  parameter int OPEN_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  gaps_pkg::cmd_t cmd,
  output gaps_pkg::sts_t sts,
  input  logic [3:0]    row,
  input  logic [3:0]    col,
  input  logic [7:0]    cell_value,
  input  logic [3:0]    dest_row,
  input  logic [3:0]    dest_col,
  output logic [2:0]    status,
  output logic [2:0]    path_row,
  output logic [2:0]    path_col,
  output logic          last
);
  import gaps_pkg::*;

  localparam int CNT_W = $clog2(OPEN_DEPTH + 1);
  localparam int IDX_W = $clog2(OPEN_DEPTH);
  localparam logic [HTAB_BITS-1:0] HTAB = h_table();

  // search request fields
  logic [3:0] sr, sc, dr, dc;
  logic [CELL_W-1:0] src_cell, dst_cell;

  // memories
  logic [7:0]        grid_mem [CELLS];
  logic [COST_W-1:0] g_mem    [CELLS];
  logic [COST_W-1:0] f_mem    [CELLS];
  logic [CELL_W-1:0] par_mem  [CELLS];
  logic [CELL_W-1:0] path_mem [CELLS];
  logic [KEY_W-1:0]  open_mem [OPEN_DEPTH];

  logic [7:0]        grid_q, src_v;
  logic [CELL_W-1:0] grid_ra;
  logic [COST_W-1:0] g_q, f_q;
  logic [CELL_W-1:0] par_q, path_q;
  logic [KEY_W-1:0]  open_q;
  logic [IDX_W-1:0]  open_ra;

  logic [CELLS-1:0]  f_set, closed;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  scan_i, best_i;
  logic [KEY_W-1:0]  best_key;
  logic              best_v;

  logic [CELL_W-1:0] cur;
  logic [2:0]        k;
  logic [COST_W-1:0] g_cur, gn, fn;
  logic [HSUM_W-1:0] hn;

  logic [CELL_W-1:0] walk;
  logic [CELL_W:0]   wn;
  logic [CELL_W-1:0] e;

  // neighbor geometry
  logic signed [4:0] ni, nj;
  logic              n_ok;
  logic [CELL_W-1:0] nb_cell;
  logic [2:0]        ad, bd;
  logic [5:0]        hidx;
  logic [HTAB_W-1:0] h_raw;
  logic [COST_W:0]   g_sum, f_sum;
  logic [KEY_W-1:0]  new_key;
  logic              src_in, dst_in;

  assign src_cell = {sr[2:0], sc[2:0]};
  assign dst_cell = {dr[2:0], dc[2:0]};

  assign ni      = $signed({2'b00, cur[5:3]}) + nb_drow(k);
  assign nj      = $signed({2'b00, cur[2:0]}) + nb_dcol(k);
  assign n_ok    = !ni[4] && !nj[4] && (ni[3:0] < 4'(GRID_ROWS)) && (nj[3:0] < 4'(GRID_COLS));
  assign nb_cell = {ni[2:0], nj[2:0]};

  // heuristic lookup and sums
  assign ad      = (ni[2:0] >= dr[2:0]) ? ni[2:0] - dr[2:0] : dr[2:0] - ni[2:0];
  assign bd      = (nj[2:0] >= dc[2:0]) ? nj[2:0] - dc[2:0] : dc[2:0] - nj[2:0];
  assign hidx    = {ad, bd};
  assign h_raw   = HTAB[int'(hidx) * HTAB_W +: HTAB_W];
  assign g_sum   = {1'b0, g_cur} + {1'b0, (k[2] ? STEP_DIAG : STEP_STRAIGHT)};
  assign f_sum   = {1'b0, gn} + (COST_W + 1)'(hn);
  assign new_key = {fn, nb_cell};

  assign src_in = (sr < 4'(GRID_ROWS)) && (sc < 4'(GRID_COLS));
  assign dst_in = (dr < 4'(GRID_ROWS)) && (dc < 4'(GRID_COLS));

  // status back to the controller
  always_comb begin
    if (!src_in || !dst_in || src_v == 8'd0) begin
      sts.chk_code = ST_RANGE;
    end else if (grid_q == 8'd0) begin
      sts.chk_code = ST_DST_BLK;
    end else if (src_cell == dst_cell) begin
      sts.chk_code = ST_SAME;
    end else begin
      sts.chk_code = ST_PATH;
    end
    sts.open_empty = (cnt == '0);
    sts.scan_last  = (CNT_W'(scan_i) == cnt - CNT_W'(1));
    sts.nb_skip    = !n_ok;
    sts.nb_dest    = n_ok && (ni[3:0] == dr) && (nj[3:0] == dc);
    sts.nb_pass    = closed[nb_cell] || (grid_q == 8'd0);
    sts.nb_better  = !f_set[nb_cell] || (f_q > fn);
    sts.open_full  = (cnt >= CNT_W'(OPEN_DEPTH));
    sts.k_last     = (k == 3'd7);
    sts.walk_stop  = (par_q == walk) || (wn == (CELL_W + 1)'(CELLS));
    sts.emit_last  = (e == '0);
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sr <= row;
      sc <= col;
      dr <= dest_row;
      dc <= dest_col;
    end
  end

  // grid memory
  assign grid_ra = cmd.chk_rd_src ? src_cell : (cmd.chk_rd_dst ? dst_cell : nb_cell);
  always_ff @(posedge clk) begin
    if (cmd.load_wr && row < 4'(GRID_ROWS) && col < 4'(GRID_COLS)) begin
      grid_mem[{row[2:0], col[2:0]}] <= cell_value;
    end
    if (cmd.chk_rd_src || cmd.chk_rd_dst || cmd.nb_rd) begin
      grid_q <= grid_mem[grid_ra];
    end
    if (cmd.chk_rd_dst) begin
      src_v <= grid_q;
    end
  end

  // g and f cost memories
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      g_mem[src_cell] <= '0;
      f_mem[src_cell] <= '0;
    end else if (cmd.nb_ins) begin
      g_mem[nb_cell] <= gn;
      f_mem[nb_cell] <= fn;
    end
    if (cmd.pop_rd) begin
      g_q <= g_mem[best_key[CELL_W-1:0]];
    end
    if (cmd.nb_rd) begin
      f_q <= f_mem[nb_cell];
    end
  end

  // parent memory
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      par_mem[src_cell] <= src_cell;
    end else if (cmd.nb_ins || cmd.nb_dst) begin
      par_mem[nb_cell] <= cur;
    end
    if (cmd.walk_rd) begin
      par_q <= par_mem[walk];
    end
  end

  // open list memory
  assign open_ra = cmd.pop_rd ? IDX_W'(cnt - CNT_W'(1)) : scan_i;
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      open_mem[0] <= {{COST_W{1'b0}}, src_cell};
    end else if (cmd.pop_wr) begin
      open_mem[best_i] <= open_q;
    end else if (cmd.nb_ins) begin
      open_mem[cnt[IDX_W-1:0]] <= new_key;
    end
    if (cmd.scan_rd || cmd.pop_rd) begin
      open_q <= open_mem[open_ra];
    end
  end

  // path list memory
  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      path_mem[wn[CELL_W-1:0]] <= walk;
    end
    if (cmd.emit_rd) begin
      path_q <= path_mem[e];
    end
  end

  // open count and visited flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      f_set  <= '0;
      closed <= '0;
    end else begin
      if (cmd.init) begin
        cnt    <= CNT_W'(1);
        f_set  <= CELLS'(1) << src_cell;
        closed <= '0;
      end else begin
        if (cmd.pop_rd) closed[best_key[CELL_W-1:0]] <= 1'b1;
        if (cmd.pop_wr) cnt <= cnt - CNT_W'(1);
        if (cmd.nb_ins) begin
          cnt <= cnt + CNT_W'(1);
          f_set[nb_cell] <= 1'b1;
        end
      end
    end
  end

  // scan for least key, pop and neighbor evaluation
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_i <= '0;
      best_v <= 1'b0;
    end
    if (cmd.scan_cmp) begin
      if (!best_v || open_q < best_key) begin
        best_key <= open_q;
        best_i   <= scan_i;
        best_v   <= 1'b1;
      end
      scan_i <= scan_i + IDX_W'(1);
    end
    if (cmd.pop_rd) cur <= best_key[CELL_W-1:0];
    if (cmd.pop_wr) begin
      g_cur <= g_q;
      k     <= '0;
    end
    if (cmd.k_inc) k <= k + 3'd1;
    if (cmd.nb_eval) begin
      gn <= g_sum[COST_W] ? QMAX : g_sum[COST_W-1:0];
      hn <= HSUM_W'(h_raw) + ((grid_q > 8'd1) ? PENALTY : '0);
    end
    if (cmd.nb_sum) fn <= f_sum[COST_W] ? QMAX : f_sum[COST_W-1:0];
  end

  // parent chain walk and reverse emit
  always_ff @(posedge clk) begin
    if (cmd.nb_dst) begin
      walk <= dst_cell;
      wn   <= '0;
    end
    if (cmd.walk_rd) wn <= wn + (CELL_W + 1)'(1);
    if (cmd.walk_step) walk <= par_q;
    if (cmd.emit_start) e <= wn[CELL_W-1:0] - CELL_W'(1);
    if (cmd.emit_dec) e <= e - CELL_W'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.set_single) begin
      status   <= cmd.single_code;
      path_row <= '0;
      path_col <= '0;
      last     <= 1'b1;
    end else if (cmd.emit_ld) begin
      status   <= ST_PATH;
      path_row <= path_q[5:3];
      path_col <= path_q[2:0];
      last     <= (e == '0);
    end
  end

endmodule

FILE: rtl/core/gaps_ctrl.sv
// ----------------------------------------------------------------------------
// gaps_ctrl
// Controller state machine: sequences checks, open list scan, expansion, emit.
// ----------------------------------------------------------------------------
module gaps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           opcode,
  output logic           out_valid,
  input  logic           out_stall,
  output gaps_pkg::cmd_t cmd,
  input  gaps_pkg::sts_t sts
);
  import gaps_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE       = 21'h000001,
    S_CHK_S      = 21'h000002,
    S_CHK_D      = 21'h000004,
    S_CHK_E      = 21'h000008,
    S_INIT       = 21'h000010,
    S_SCAN_START = 21'h000020,
    S_SCAN_RD    = 21'h000040,
    S_SCAN_CMP   = 21'h000080,
    S_POP_RD     = 21'h000100,
    S_POP_WR     = 21'h000200,
    S_NB_CHK     = 21'h000400,
    S_NB_EV      = 21'h000800,
    S_NB_SUM     = 21'h001000,
    S_NB_UPD     = 21'h002000,
    S_NB_NEXT    = 21'h004000,
    S_WALK_RD    = 21'h008000,
    S_WALK_CHK   = 21'h010000,
    S_EMIT_RD    = 21'h020000,
    S_EMIT_LD    = 21'h040000,
    S_EMIT_OUT   = 21'h080000,
    S_SINGLE_OUT = 21'h100000
  } state_t;

  state_t state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EMIT_OUT) || (state == S_SINGLE_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (opcode == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            state_next = S_CHK_S;
          end
        end
      end
      S_CHK_S: begin
        cmd.chk_rd_src = 1'b1;
        state_next     = S_CHK_D;
      end
      S_CHK_D: begin
        cmd.chk_rd_dst = 1'b1;
        state_next     = S_CHK_E;
      end
      S_CHK_E: begin
        if (sts.chk_code != ST_PATH) begin
          cmd.set_single  = 1'b1;
          cmd.single_code = sts.chk_code;
          state_next      = S_SINGLE_OUT;
        end else begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_SCAN_START;
      end
      S_SCAN_START: begin
        if (sts.open_empty) begin
          cmd.set_single  = 1'b1;
          cmd.single_code = ST_NO_PATH;
          state_next      = S_SINGLE_OUT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_next   = sts.scan_last ? S_POP_RD : S_SCAN_RD;
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = S_POP_WR;
      end
      S_POP_WR: begin
        cmd.pop_wr = 1'b1;
        state_next = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (sts.nb_skip) begin
          state_next = S_NB_NEXT;
        end else if (sts.nb_dest) begin
          cmd.nb_dst = 1'b1;
          state_next = S_WALK_RD;
        end else begin
          cmd.nb_rd  = 1'b1;
          state_next = S_NB_EV;
        end
      end
      S_NB_EV: begin
        if (sts.nb_pass) begin
          state_next = S_NB_NEXT;
        end else begin
          cmd.nb_eval = 1'b1;
          state_next  = S_NB_SUM;
        end
      end
      S_NB_SUM: begin
        cmd.nb_sum = 1'b1;
        state_next = S_NB_UPD;
      end
      S_NB_UPD: begin
        if (!sts.nb_better) begin
          state_next = S_NB_NEXT;
        end else if (sts.open_full) begin
          cmd.set_single  = 1'b1;
          cmd.single_code = ST_OVERFLOW;
          state_next      = S_SINGLE_OUT;
        end else begin
          cmd.nb_ins = 1'b1;
          state_next = S_NB_NEXT;
        end
      end
      S_NB_NEXT: begin
        if (sts.k_last) begin
          state_next = S_SCAN_START;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_NB_CHK;
        end
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (sts.walk_stop) begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT_RD;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = S_WALK_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (!out_stall) begin
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.emit_dec = 1'b1;
            state_next   = S_EMIT_RD;
          end
        end
      end
      S_SINGLE_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/grid_astar_path_search_core.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search_core
// A* path search over an 8-neighbor grid with a linear-scan open list.
// ----------------------------------------------------------------------------
// Load requests are accepted back to back.
// A search request holds off input until its last result is taken.
// Checks read the source and destination cells and judge them; an error result is
// offered, else setup follows. Each pop scans the open list, then visits neighbors.
// The path walk follows parents back from the destination; cells emit source first.
// Reset clears the controller, open count and visited flags; grid is kept.
module grid_astar_path_search_core #(
  parameter int GRID_ROWS  = 8,
  parameter int GRID_COLS  = 8,
  parameter int OPEN_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [3:0] row,
  input  logic [3:0] col,
  input  logic [7:0] cell_value,
  input  logic [3:0] dest_row,
  input  logic [3:0] dest_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [2:0] path_row,
  output logic [2:0] path_col,
  output logic       last
);
  import gaps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  gaps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and arithmetic
  gaps_dpath #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_COLS  (GRID_COLS),
    .OPEN_DEPTH (OPEN_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .row        (row),
    .col        (col),
    .cell_value (cell_value),
    .dest_row   (dest_row),
    .dest_col   (dest_col),
    .status     (status),
    .path_row   (path_row),
    .path_col   (path_col),
    .last       (last)
  );

endmodule

FILE: rtl/core/gaps_checker.sv
// ----------------------------------------------------------------------------
// gaps_checker
// Port-level checks for the grid A* path search core.
// ----------------------------------------------------------------------------
module gaps_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       opcode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [2:0] path_row,
  input logic [2:0] path_col,
  input logic       last
);
  import gaps_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // no new request while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // error results are single and carry no cell
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_PATH |-> last && path_row == 3'd0 && path_col == 3'd0)
    else $error("bad error result");

  // a load request produces no result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OP_LOAD |=> !out_valid)
    else $error("result after load");

endmodule

bind grid_astar_path_search_core gaps_checker u_gaps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .opcode    (opcode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .path_row  (path_row),
  .path_col  (path_col),
  .last      (last)
);
